// ===== hw/rtl/fracr_pkg.sv =====
// ----------------------------------------------------------------------------
// fracr_pkg
// Shared widths and defaults for the fraction accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fracr_pkg;

  // width of the numerator and denominator ports
  localparam int unsigned DataBits = 32;

  // default internal arithmetic width
  localparam int unsigned WordBitsDefault = 32;

endpackage

`default_nettype wire

// ===== hw/rtl/fraction_accumulate_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_accumulate_reduce
// Running fraction accumulator with Euclid gcd reduction on one shared unit.
// ----------------------------------------------------------------------------
// A first transaction loads the accumulator without the unit. Every other
// transaction is worked through one shared shift-subtract divider / shift-add
// multiplier. Add runs both Euclid loops (one divide per remainder step) plus
// eight more operations; multiply runs one Euclid loop plus four operations.
// An add with a zero denominator is flagged without the unit. in_ready_o is
// low while an item is worked. The result of a last item sits in an output
// register, so the next item is taken while it waits; a later last item holds
// in its final cycle until that register is free.
`default_nettype none

module fraction_accumulate_reduce #(
  parameter int unsigned WORD_BITS = fracr_pkg::WordBitsDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  req_type_i,
  input  wire logic                                  first_i,
  input  wire logic                                  last_i,
  input  wire logic signed [fracr_pkg::DataBits-1:0] in_num_i,
  input  wire logic signed [fracr_pkg::DataBits-1:0] in_den_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [fracr_pkg::DataBits-1:0]      res_num_o,
  output logic signed [fracr_pkg::DataBits-1:0]      res_den_o,
  output logic                                       div_error_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned DB = fracr_pkg::DataBits;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StGcd1  = 4'd1;
  localparam logic [3:0] StLcmP  = 4'd2;
  localparam logic [3:0] StLcm   = 4'd3;
  localparam logic [3:0] StS1Q   = 4'd4;
  localparam logic [3:0] StS1    = 4'd5;
  localparam logic [3:0] StS2Q   = 4'd6;
  localparam logic [3:0] StS2    = 4'd7;
  localparam logic [3:0] StGcd2  = 4'd8;
  localparam logic [3:0] StRn    = 4'd9;
  localparam logic [3:0] StRd    = 4'd10;
  localparam logic [3:0] StMPn   = 4'd11;
  localparam logic [3:0] StMPd   = 4'd12;
  localparam logic [3:0] StEmit  = 4'd13;

  // ---------------------------------------------------------------- sequencer
  logic [3:0]   state_q, state_d;
  logic [W-1:0] acc_num_q, acc_num_d, acc_den_q, acc_den_d;
  logic         err_q, err_d;
  logic [W-1:0] n2_q, n2_d, d2_q, d2_d;
  logic [W-1:0] b_q, b_d;                  // euclid divisor
  logic [W-1:0] s_q, s_d, l_q, l_d;        // numerator / denominator before reduce
  logic [W-1:0] t_q, t_d;
  logic         last_q, last_d;
  logic         ov_q, ov_d;
  logic [W-1:0] on_q, on_d, od_q, od_d;
  logic         oe_q, oe_d;

  // unit request
  logic         u_start, u_mul;
  logic [W-1:0] u_a, u_b;
  // unit state
  logic         u_busy_q, u_done_q, u_is_mul_q, u_negq_q, u_negr_q;
  logic [CW-1:0] u_cnt_q;
  logic [W-1:0] u_x_q, u_y_q, u_r_q;
  logic [W-1:0] u_quo, u_rem, u_prod;

  logic [W-1:0] n_in, d_in;
  assign n_in = W'(in_num_i);
  assign d_in = W'(in_den_i);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    acc_num_d = acc_num_q;
    acc_den_d = acc_den_q;
    err_d     = err_q;
    n2_d      = n2_q;
    d2_d      = d2_q;
    b_d       = b_q;
    s_d       = s_q;
    l_d       = l_q;
    t_d       = t_q;
    last_d    = last_q;
    ov_d      = ov_q & ~out_ready_i;
    on_d      = on_q;
    od_d      = od_q;
    oe_d      = oe_q;
    u_start   = 1'b0;
    u_mul     = 1'b0;
    u_a       = '0;
    u_b       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          n2_d   = n_in;
          d2_d   = d_in;
          last_d = last_i;
          if (first_i) begin
            acc_num_d = n_in;
            acc_den_d = d_in;
            err_d     = 1'b0;
            state_d   = StEmit;
          end else if (req_type_i) begin
            u_start = 1'b1;
            u_mul   = 1'b1;
            u_a     = acc_num_q;
            u_b     = n_in;
            state_d = StMPn;
          end else if (d_in == '0) begin
            err_d   = 1'b1;
            state_d = StEmit;
          end else begin
            b_d     = d_in;
            u_start = 1'b1;
            u_a     = acc_den_q;
            u_b     = d_in;
            state_d = StGcd1;
          end
        end
      end
      StGcd1, StGcd2: begin
        if (u_done_q) begin
          u_start = 1'b1;
          if (u_rem != '0) begin
            b_d = u_rem;
            u_a = b_q;
            u_b = u_rem;
          end else if (state_q == StGcd1) begin
            // lcm = d1*d2 / g, g held in b_q
            u_mul   = 1'b1;
            u_a     = acc_den_q;
            u_b     = d2_q;
            state_d = StLcmP;
          end else begin
            u_a     = s_q;
            u_b     = b_q;
            state_d = StRn;
          end
        end
      end
      StLcmP: begin
        if (u_done_q) begin
          u_start = 1'b1;
          u_a     = u_prod;
          u_b     = b_q;
          state_d = StLcm;
        end
      end
      StLcm: begin
        if (u_done_q) begin
          l_d = u_quo;
          if (acc_den_q == '0) begin
            err_d   = 1'b1;
            state_d = StEmit;
          end else begin
            u_start = 1'b1;
            u_a     = u_quo;
            u_b     = acc_den_q;
            state_d = StS1Q;
          end
        end
      end
      StS1Q: begin
        if (u_done_q) begin
          u_start = 1'b1;
          u_mul   = 1'b1;
          u_a     = u_quo;
          u_b     = acc_num_q;
          state_d = StS1;
        end
      end
      StS1: begin
        if (u_done_q) begin
          t_d     = u_prod;
          u_start = 1'b1;
          u_a     = l_q;
          u_b     = d2_q;
          state_d = StS2Q;
        end
      end
      StS2Q: begin
        if (u_done_q) begin
          u_start = 1'b1;
          u_mul   = 1'b1;
          u_a     = u_quo;
          u_b     = n2_q;
          state_d = StS2;
        end
      end
      StS2: begin
        if (u_done_q) begin
          s_d = t_q + u_prod;
          if (l_q == '0) begin
            err_d   = 1'b1;
            state_d = StEmit;
          end else begin
            b_d     = l_q;
            u_start = 1'b1;
            u_a     = t_q + u_prod;
            u_b     = l_q;
            state_d = StGcd2;
          end
        end
      end
      StMPn: begin
        if (u_done_q) begin
          s_d     = u_prod;
          u_start = 1'b1;
          u_mul   = 1'b1;
          u_a     = acc_den_q;
          u_b     = d2_q;
          state_d = StMPd;
        end
      end
      StMPd: begin
        if (u_done_q) begin
          l_d = u_prod;
          if (u_prod == '0) begin
            err_d   = 1'b1;
            state_d = StEmit;
          end else begin
            b_d     = u_prod;
            u_start = 1'b1;
            u_a     = s_q;
            u_b     = u_prod;
            state_d = StGcd2;
          end
        end
      end
      StRn: begin
        if (u_done_q) begin
          t_d     = u_quo;
          u_start = 1'b1;
          u_a     = l_q;
          u_b     = b_q;
          state_d = StRd;
        end
      end
      StRd: begin
        if (u_done_q) begin
          acc_num_d = t_q;
          acc_den_d = u_quo;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oe_d    = err_q;
          on_d    = err_q ? '0 : acc_num_q;
          od_d    = err_q ? '0 : acc_den_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      acc_num_q <= '0;
      acc_den_q <= '0;
      err_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
      err_q     <= err_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_q   <= n2_d;
    d2_q   <= d2_d;
    b_q    <= b_d;
    s_q    <= s_d;
    l_q    <= l_d;
    t_q    <= t_d;
    last_q <= last_d;
    on_q   <= on_d;
    od_q   <= od_d;
    oe_q   <= oe_d;
  end

  // ------------------------------------------------- shared div / mul unit
  logic [W-1:0] abs_a, abs_b;
  logic [W:0]   shl, diff;
  assign abs_a = u_a[W-1] ? (W'(0) - u_a) : u_a;
  assign abs_b = u_b[W-1] ? (W'(0) - u_b) : u_b;
  assign shl   = {u_r_q, u_y_q[W-1]};
  assign diff  = shl - {1'b0, u_x_q};

  assign u_quo  = u_negq_q ? (W'(0) - u_y_q) : u_y_q;
  assign u_rem  = u_negr_q ? (W'(0) - u_r_q) : u_r_q;
  assign u_prod = u_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_busy_q <= 1'b0;
      u_done_q <= 1'b0;
      u_cnt_q  <= '0;
    end else begin
      u_done_q <= 1'b0;
      if (u_start) begin
        u_busy_q <= 1'b1;
        u_cnt_q  <= '0;
      end else if (u_busy_q) begin
        u_cnt_q <= u_cnt_q + CW'(1);
        if (u_cnt_q == CW'(W - 1)) begin
          u_busy_q <= 1'b0;
          u_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_start) begin
      u_is_mul_q <= u_mul;
      u_r_q      <= '0;
      if (u_mul) begin
        u_x_q <= u_a;
        u_y_q <= u_b;
      end else begin
        // divisor magnitude in x, dividend magnitude shifts out of y
        u_x_q    <= abs_b;
        u_y_q    <= abs_a;
        u_negq_q <= u_a[W-1] ^ u_b[W-1];
        u_negr_q <= u_a[W-1];
      end
    end else if (u_busy_q) begin
      if (u_is_mul_q) begin
        u_r_q <= u_r_q + (u_y_q[0] ? u_x_q : '0);
        u_x_q <= {u_x_q[W-2:0], 1'b0};
        u_y_q <= {1'b0, u_y_q[W-1:1]};
      end else if (!diff[W]) begin
        u_r_q <= diff[W-1:0];
        u_y_q <= {u_y_q[W-2:0], 1'b1};
      end else begin
        u_r_q <= shl[W-1:0];
        u_y_q <= {u_y_q[W-2:0], 1'b0};
      end
    end
  end

  assign out_valid_o = ov_q;
  assign res_num_o   = DB'(on_q);
  assign res_den_o   = DB'(od_q);
  assign div_error_o = oe_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fracr_checker.sv =====
// ----------------------------------------------------------------------------
// fracr_checker
// Port-level checks for the fraction accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fracr_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_ready_o,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_ready_i,
  input wire logic signed [fracr_pkg::DataBits-1:0] res_num_o,
  input wire logic signed [fracr_pkg::DataBits-1:0] res_den_o,
  input wire logic                                  div_error_o
);

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_num_o) && $stable(res_den_o))
    else $error("result dropped or changed while stalled");

  // an error result carries a zero fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_error_o |-> res_num_o == '0 && res_den_o == '0)
    else $error("error result with nonzero fraction");

  // one item at a time: ready drops after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a result never appears in the cycle after the transaction that causes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result before item worked");

endmodule

bind fraction_accumulate_reduce fracr_checker u_fracr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .res_num_o   (res_num_o),
  .res_den_o   (res_den_o),
  .div_error_o (div_error_o)
);

`default_nettype wire
